// ===== rtl/nst_pkg.sv =====
// ---------------------------------------------------------------------------
// nst_pkg
// Shared types and constants for the neighbour set table: request codes,
// controller states and the command/status bundles between control and data.
// ---------------------------------------------------------------------------
package nst_pkg;

    localparam int MAX_NEIGHBORS_DEF = 64;
    localparam int INDEX_BITS_DEF    = 16;

    localparam int REQ_W    = 3;
    localparam int TARGET_W = 16;
    localparam int COUNT_W  = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND        = 3'd0,
        REQ_APPEND_ABSENT = 3'd1,
        REQ_QUERY         = 3'd2,
        REQ_REMOVE        = 3'd3,
        REQ_CLEAR         = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_ACT,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_NEXT,
        RD_TAIL
    } t_rd_sel;

    typedef struct packed {
        logic    load_req;
        t_rd_sel rd_sel;
        logic    inc_k;
        logic    dec_cnt;
        logic    inc_cnt;
        logic    clr_cnt;
        logic    set_found;
        logic    inc_removed;
        logic    set_status;
        logic    wr_tail;
        logic    wr_append;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic match;
        logic k_last;
        logic cnt_zero;
        logic cnt_full;
        logic found;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/nst_datapath.sv =====
// ---------------------------------------------------------------------------
// nst_datapath
// Entry memory, scan index, entry count, result flags and output register.
// ---------------------------------------------------------------------------
module nst_datapath #(
    parameter int MAX_NEIGHBORS = nst_pkg::MAX_NEIGHBORS_DEF,
    parameter int INDEX_BITS    = nst_pkg::INDEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [nst_pkg::REQ_W-1:0]     i_req_type,
    input  logic [nst_pkg::TARGET_W-1:0]  i_target,
    input  logic                          i_stall,
    input  nst_pkg::t_cmd                 i_cmd,
    output nst_pkg::t_sts                 o_sts,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [nst_pkg::COUNT_W-1:0]   o_removed_count,
    output logic [nst_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                          o_status
);
    import nst_pkg::*;

    localparam int KW      = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW      = $clog2(MAX_NEIGHBORS + 1);
    localparam int KEY_EXT = (INDEX_BITS > TARGET_W) ? INDEX_BITS : TARGET_W;

    logic [INDEX_BITS-1:0] r_mem [MAX_NEIGHBORS];
    logic [INDEX_BITS-1:0] r_rdata;

    t_req                  r_req;
    logic [INDEX_BITS-1:0] r_key;
    logic [KW-1:0]         r_k;
    logic [CW-1:0]         r_cnt;
    logic                  r_found;
    logic [CW-1:0]         r_removed;
    logic                  r_status;

    logic                  r_o_valid;
    logic                  r_o_found;
    logic [COUNT_W-1:0]    r_o_removed;
    logic [COUNT_W-1:0]    r_o_entry;
    logic                  r_o_status;

    logic [KEY_EXT-1:0]    w_key_ext;
    logic [CW-1:0]         w_tail_idx;
    logic [KW-1:0]         w_rd_addr;
    logic                  w_wr_en;
    logic [KW-1:0]         w_wr_addr;
    logic [INDEX_BITS-1:0] w_wr_data;

    assign w_key_ext  = KEY_EXT'(i_target);
    assign w_tail_idx = r_cnt - CW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_NEXT: w_rd_addr = r_k + KW'(1);
            RD_TAIL: w_rd_addr = w_tail_idx[KW-1:0];
            default: w_rd_addr = '0;
        endcase
    end

    always_comb begin
        w_wr_en   = i_cmd.wr_tail | i_cmd.wr_append;
        w_wr_addr = i_cmd.wr_append ? r_cnt[KW-1:0] : r_k;
        w_wr_data = i_cmd.wr_append ? r_key : r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req     <= t_req'(i_req_type);
            r_key     <= w_key_ext[INDEX_BITS-1:0];
            r_k       <= '0;
            r_found   <= 1'b0;
            r_removed <= '0;
            r_status  <= 1'b0;
        end else begin
            if (i_cmd.inc_k) begin
                r_k <= r_k + KW'(1);
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
            if (i_cmd.inc_removed) begin
                r_removed <= r_removed + CW'(1);
            end
            if (i_cmd.set_status) begin
                r_status <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_cnt) begin
            r_cnt <= '0;
        end else if (i_cmd.dec_cnt) begin
            r_cnt <= r_cnt - CW'(1);
        end else if (i_cmd.inc_cnt) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // output register: holds the result transaction until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_found   <= r_found;
            r_o_removed <= COUNT_W'(r_removed);
            r_o_entry   <= COUNT_W'(r_cnt);
            r_o_status  <= r_status;
        end
    end

    always_comb begin
        o_sts.req      = r_req;
        o_sts.match    = (r_rdata == r_key);
        o_sts.k_last   = ((CW'(r_k) + CW'(1)) == r_cnt);
        o_sts.cnt_zero = (r_cnt == '0);
        o_sts.cnt_full = (r_cnt == CW'(MAX_NEIGHBORS));
        o_sts.found    = r_found;
        o_sts.out_free = !r_o_valid || !i_stall;
    end

    assign o_valid         = r_o_valid;
    assign o_found         = r_o_found;
    assign o_removed_count = r_o_removed;
    assign o_entry_count   = r_o_entry;
    assign o_status        = r_o_status;

endmodule

// ===== rtl/nst_ctrl.sv =====
// ---------------------------------------------------------------------------
// nst_ctrl
// Request sequencer: scan, swap-with-tail removal, append/clear, result load.
// ---------------------------------------------------------------------------
module nst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  nst_pkg::t_sts  i_sts,
    output nst_pkg::t_cmd  o_cmd
);
    import nst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.cnt_zero ? ST_ACT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.req == REQ_REMOVE && i_sts.match) begin
                    n_state = i_sts.k_last ? ST_ACT : ST_TAIL;
                end else begin
                    n_state = i_sts.k_last ? ST_ACT : ST_SCAN;
                end
            end
            ST_TAIL: begin
                if (i_sts.match) begin
                    n_state = i_sts.k_last ? ST_ACT : ST_TAIL;
                end else begin
                    n_state = i_sts.k_last ? ST_ACT : ST_SCAN;
                end
            end
            ST_ACT: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_ZERO;
        o_stall      = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.load_req = i_valid;
            end
            ST_SCAN: begin
                if (i_sts.req == REQ_REMOVE && i_sts.match) begin
                    o_cmd.dec_cnt     = 1'b1;
                    o_cmd.inc_removed = 1'b1;
                    o_cmd.set_found   = 1'b1;
                    o_cmd.rd_sel      = RD_TAIL;
                end else begin
                    o_cmd.set_found = i_sts.match;
                    if (!i_sts.k_last) begin
                        o_cmd.inc_k  = 1'b1;
                        o_cmd.rd_sel = RD_NEXT;
                    end
                end
            end
            ST_TAIL: begin
                // moved tail entry lands in the freed slot and is checked again
                o_cmd.wr_tail = 1'b1;
                if (i_sts.match) begin
                    o_cmd.dec_cnt     = 1'b1;
                    o_cmd.inc_removed = 1'b1;
                    o_cmd.rd_sel      = RD_TAIL;
                end else if (!i_sts.k_last) begin
                    o_cmd.inc_k  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                end
            end
            ST_ACT: begin
                case (i_sts.req)
                    REQ_APPEND: begin
                        o_cmd.set_status = i_sts.cnt_full;
                        o_cmd.wr_append  = !i_sts.cnt_full;
                        o_cmd.inc_cnt    = !i_sts.cnt_full;
                    end
                    REQ_APPEND_ABSENT: begin
                        o_cmd.set_status = !i_sts.found && i_sts.cnt_full;
                        o_cmd.wr_append  = !i_sts.found && !i_sts.cnt_full;
                        o_cmd.inc_cnt    = !i_sts.found && !i_sts.cnt_full;
                    end
                    REQ_CLEAR: begin
                        o_cmd.clr_cnt = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_FINISH: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/neighbor_set_table.sv =====
// ---------------------------------------------------------------------------
// neighbor_set_table
// Bounded neighbour index list with append, conditional append, query,
// remove-all and clear requests; one result transaction per request.
// ---------------------------------------------------------------------------
// Sequence: the request is taken in idle, the stored entries are scanned
//   one slot a cycle (a slot refilled from the tail is checked again; no
//   scan when empty), then act; finish loads the output register once free.
// Flow: a request is taken while a result waits; a held result stalls it.
// Reset: entry count and handshake state cleared; entry memory not cleared.
// ---------------------------------------------------------------------------
module neighbor_set_table #(
    parameter int MAX_NEIGHBORS = nst_pkg::MAX_NEIGHBORS_DEF,
    parameter int INDEX_BITS    = nst_pkg::INDEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [nst_pkg::REQ_W-1:0]     i_req_type,
    input  logic [nst_pkg::TARGET_W-1:0]  i_target,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [nst_pkg::COUNT_W-1:0]   o_removed_count,
    output logic [nst_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                          o_status
);
    import nst_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    nst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    nst_datapath #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .INDEX_BITS    (INDEX_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (i_req_type),
        .i_target        (i_target),
        .i_stall         (i_stall),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_removed_count (o_removed_count),
        .o_entry_count   (o_entry_count),
        .o_status        (o_status)
    );

endmodule

// ===== rtl/nst_checker.sv =====
// ---------------------------------------------------------------------------
// nst_checker
// Port-level checks for the neighbour set table, bound to the top level.
// ---------------------------------------------------------------------------
module nst_checker #(
    parameter int MAX_NEIGHBORS = nst_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic                          o_found,
    input  logic [nst_pkg::COUNT_W-1:0]   o_removed_count,
    input  logic [nst_pkg::COUNT_W-1:0]   o_entry_count,
    input  logic                          o_status
);
    import nst_pkg::*;

    // a request transaction is never followed by another in the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted back to back");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({25'b0, o_entry_count} <= MAX_NEIGHBORS))
        else $error("entry count beyond capacity");

    a_removed_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_removed_count != '0) |-> o_found)
        else $error("entries removed but target not reported found");

    a_full_no_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_removed_count == '0))
        else $error("full status on a remove result");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_entry_count)
                                  && $stable(o_found) && $stable(o_status)))
        else $error("stalled result transaction changed");

endmodule

bind neighbor_set_table nst_checker #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_nst_checker (.*);
